// File: hdl/bpa_pkg.sv
// Shared types and constants of the butterfly path allocator.
package bpa_pkg;

    // Width used for stage counts inside the block; holds any count up to fifteen.
    localparam int STAGE_W = 4;

    // Width of the stage count register.
    localparam int CFG_W = 3;

    // Reset value of the stage count register.
    localparam logic [CFG_W-1:0] CFG_STAGES_RESET = 3'd4;

    // Smallest stage count the network is built with.
    localparam logic [STAGE_W-1:0] MIN_STAGES = 4'd2;

    // Register index of the stage count register.
    localparam logic REG_STAGE_COUNT = 1'b0;

    // Item kinds carried in the action field.
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_ROUTE = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_GRANT    = 3'd0,
        ST_CONFLICT = 3'd1,
        ST_BLOCKED  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

endpackage

// File: hdl/butterfly_path_allocator.sv
// Top level of the butterfly path allocator: request decode, path check and busy bits.
//
// Usage
//   The block keeps one busy bit for every channel of a radix-2 butterfly and answers
//   each request item on the slave stream with one status item on the master stream.
//   A clear item (action 0) frees every channel and answers "round cleared". A route item
//   (action 1) names a source and a destination node; its whole path is checked and, when
//   every channel is free and the destination is not blocked, marked busy. The user must
//   write the stage count over the APB port only while no item is in flight (unenforced).
// Output timing and throughput
//   The status appears on the master stream in the cycle after the item is taken. One
//   item is taken every cycle unless the master stream stalls: all channel indices of
//   a path are formed at once and looked up in the busy-bit register, so the
//   read-check-update of that register completes within the accepting cycle.
// Reset
//   aresetn low frees every channel, empties the output register and sets the stage
//   count to four.
// Stalls
//   While a status waits and m_tready is low, s_tready is low; when the waiting status
//   is taken in a cycle, a new item can be taken in that same cycle.
module butterfly_path_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_STAGES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: from_node [3:0], to_node [7:4], dest_blocked [8].
    input  logic [15:0] s_tdata,
    // s_tuser fields from bit 0: action [0].
    input  logic        s_tuser,
    // Status stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: status [2:0].
    output logic [7:0]  m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NODES    = 1 << MAX_STAGES;
    localparam int CHANNELS = (MAX_STAGES + 1) * NODES;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int NODE_W   = MAX_STAGES;

    logic [CFG_W-1:0]    stage_count_reg;
    logic [CHANNELS-1:0] busy_reg;
    logic [CHANNELS-1:0] busy_next;
    status_t             status_reg;
    status_t             status_next;
    logic                out_valid_reg;

    logic                in_accept;
    logic                cfg_write;
    logic [STAGE_W-1:0]  stages;
    logic [3:0]          from_node;
    logic [3:0]          to_node;
    logic                dest_blocked;
    logic                action;
    logic                out_of_range;
    logic                conflict;
    logic [CHANNELS-1:0] path_mask;

    assign from_node    = s_tdata[3:0];
    assign to_node      = s_tdata[7:4];
    assign dest_blocked = s_tdata[8];
    assign action       = s_tuser;

    // Handshakes: a new item enters whenever the output register is empty or drains.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, status_reg};

    // APB port: always ready, one register at word index zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_STAGE_COUNT);
    assign prdata    = (paddr[2] == REG_STAGE_COUNT) ?
                       {{(32-CFG_W){1'b0}}, stage_count_reg} : 32'd0;

    // Effective stage count: raised to the minimum first, then limited to the build size.
    always_comb begin
        stages = STAGE_W'(stage_count_reg);
        if (stages < MIN_STAGES) begin
            stages = MIN_STAGES;
        end
        if (stages > STAGE_W'(MAX_STAGES)) begin
            stages = STAGE_W'(MAX_STAGES);
        end
    end

    // A node is out of range when any bit at or above the stage count is set.
    assign out_of_range = ((from_node >> stages) != 4'd0) || ((to_node >> stages) != 4'd0);

    // Path walk: every column's channel index is formed and checked against the busy bits.
    always_comb begin
        logic [NODE_W-1:0] sw;
        logic [NODE_W-1:0] flip;
        logic [3:0]        dst_shift;
        logic              dbit;
        logic [CH_W-1:0]   idx;
        logic [CH_W-1:0]   col_base;

        path_mask = '0;
        conflict  = 1'b0;
        sw        = NODE_W'(from_node >> 1);
        flip      = '0;
        dst_shift = '0;
        dbit      = 1'b0;

        // Column zero carries the source node's own channel.
        idx       = CH_W'(from_node);
        path_mask = path_mask | (CHANNELS'(1) << idx);
        conflict  = conflict | busy_reg[idx];

        // Middle columns follow the destination bits from the top down.
        for (int i = 1; i < MAX_STAGES; i++) begin
            if (i < int'(stages)) begin
                dst_shift = to_node >> (stages - STAGE_W'(i));
                dbit      = dst_shift[0];
                col_base  = CH_W'(CH_W'(i) << stages);
                idx       = col_base + CH_W'({sw, dbit});
                path_mask = path_mask | (CHANNELS'(1) << idx);
                conflict  = conflict | busy_reg[idx];
                flip      = NODE_W'(1) << (stages - STAGE_W'(i) - STAGE_W'(1));
                sw        = dbit ? (sw | flip) : (sw & ~flip);
            end
        end

        // The last column carries the destination node's channel.
        col_base  = CH_W'(CH_W'(stages) << stages);
        idx       = col_base + CH_W'(to_node);
        path_mask = path_mask | (CHANNELS'(1) << idx);
        conflict  = conflict | busy_reg[idx];
    end

    // Decision for the item on the input: status and the busy bits it leaves.
    always_comb begin
        busy_next   = busy_reg;
        status_next = ST_GRANT;
        if (action == ACT_CLEAR) begin
            busy_next   = '0;
            status_next = ST_CLEARED;
        end else if (out_of_range) begin
            status_next = ST_RANGE;
        end else if (dest_blocked) begin
            status_next = ST_BLOCKED;
        end else if (conflict) begin
            status_next = ST_CONFLICT;
        end else begin
            busy_next   = busy_reg | path_mask;
            status_next = ST_GRANT;
        end
    end

    // Control state: busy bits, output valid and the stage count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= '0;
            out_valid_reg   <= 1'b0;
            stage_count_reg <= CFG_STAGES_RESET;
        end else begin
            if (in_accept) begin
                busy_reg      <= busy_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                stage_count_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Result register: loaded with the status of each item taken.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            status_reg <= status_next;
        end
    end

endmodule

// File: hdl/bpa_checker.sv
// Port-level checks of the butterfly path allocator and their bind to the top level.
module bpa_checker
    import bpa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A waiting status holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("status item changed or vanished while stalled");

    // A clear item is answered in the next cycle with "round cleared".
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_CLEAR)
        |=> m_tvalid && (m_tdata[2:0] == ST_CLEARED))
        else $error("clear item not answered as round cleared");

    // A blocked request between node zero and node zero is always refused as blocked.
    a_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_ROUTE) && s_tdata[8]
        && (s_tdata[7:0] == 8'd0)
        |=> m_tvalid && (m_tdata[2:0] == ST_BLOCKED))
        else $error("blocked request not refused as blocked");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("status item present after reset");

    // Only defined status codes are ever presented.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= 8'(ST_CLEARED)))
        else $error("undefined status code presented");

endmodule

bind butterfly_path_allocator bpa_checker u_bpa_checker (.*);
